// ===== rtl/bfcs_pkg.sv =====
// Types, constants and slot schedule for the bubble field cycle sequencer.
package bfcs_pkg;

  localparam int SLOT_W      = 10;
  localparam int LOOP_W      = 10;
  localparam int CFG_W       = 10;
  localparam int SCHED_AW    = 6;
  localparam int SCHED_DEPTH = 1 << SCHED_AW;

  localparam logic [CFG_W-1:0] LONG_RESET  = 10'd300;
  localparam logic [CFG_W-1:0] SHORT_RESET = 10'd70;

  localparam int COIL_SHIFT = -3;
  localparam int COIL_WIDTH = 12;
  localparam int COIL_GAP   = 10;
  localparam int LEAD_IN    = 10;
  localparam int REF_SLOT   = LEAD_IN + COIL_GAP;
  localparam int GEN_AT     = 1;
  localparam int GEN_WIDTH  = 1;
  localparam int ANN_AT     = 14 - 3;
  localparam int ANN_WIDTH  = 19 + 3;
  localparam int XIN_AT     = -2;
  localparam int XIN_WIDTH  = 15;
  localparam int XOUT_AT    = 19 - 2;
  localparam int XOUT_WIDTH = 14;
  localparam int STR_ON     = 7;
  localparam int STR_OFF    = 8 + 20;

  localparam logic [3:0] B_XA = 4'b0001;
  localparam logic [3:0] B_XB = 4'b0010;
  localparam logic [3:0] B_YA = 4'b0100;
  localparam logic [3:0] B_YB = 4'b1000;
  localparam logic [1:0] E_X  = 2'b01;
  localparam logic [1:0] E_Y  = 2'b10;

  typedef enum logic {
    REG_LONG  = 1'b0,
    REG_SHORT = 1'b1
  } cfg_reg_t;

  typedef struct packed {
    logic       action;
    logic [4:0] function_mask;
    logic       detect_mode;
    logic       detector_level;
  } in_item_t;

  typedef struct packed {
    logic [3:0]        bridge_inputs;
    logic [1:0]        bridge_enables;
    logic [4:0]        function_pins;
    logic              drive_safety;
    logic              busy_res;
    logic              cycle_done;
    logic              detected_bit;
    logic [LOOP_W-1:0] loop_position;
  } out_item_t;

  // edge masks for one slot; pin edges are unmasked here, held mask applies later
  typedef struct packed {
    logic [3:0] bridge_set;
    logic [3:0] bridge_clr;
    logic [1:0] en_set;
    logic [1:0] en_clr;
    logic [4:0] pin_set;
    logic [4:0] pin_clr;
    logic       pin_clr_all;
  } sched_t;

  function automatic sched_t sched_entry(input logic [SCHED_AW-1:0] addr);
    sched_t     e;
    int         s;
    int         start;
    logic [3:0] on_b;
    logic [3:0] off_b;
    logic [1:0] en_b;
    e = '0;
    s = int'(addr);
    if (s == 0) begin
      e.pin_clr_all = 1'b1;
      e.en_clr      = E_X | E_Y;
    end
    for (int n = 0; n < 5; n++) begin
      start = LEAD_IN + n * COIL_GAP + COIL_SHIFT;
      case (n % 4)
        0: begin on_b = B_YA; off_b = B_YB; en_b = E_Y; end
        1: begin on_b = B_XB; off_b = B_XA; en_b = E_X; end
        2: begin on_b = B_YB; off_b = B_YA; en_b = E_Y; end
        default: begin on_b = B_XA; off_b = B_XB; en_b = E_X; end
      endcase
      if (s == start) begin
        e.bridge_set = e.bridge_set | on_b;
        e.bridge_clr = e.bridge_clr | off_b;
        e.en_set     = e.en_set | en_b;
      end
      if (s == start + COIL_WIDTH) begin
        e.en_clr     = e.en_clr | en_b;
        e.bridge_clr = e.bridge_clr | on_b;
      end
    end
    if (s == REF_SLOT + GEN_AT)               e.pin_set[0] = 1'b1;
    if (s == REF_SLOT + GEN_AT + GEN_WIDTH)   e.pin_clr[0] = 1'b1;
    if (s == REF_SLOT + ANN_AT)               e.pin_set[1] = 1'b1;
    if (s == REF_SLOT + ANN_AT + ANN_WIDTH)   e.pin_clr[1] = 1'b1;
    if (s == REF_SLOT + XIN_AT)               e.pin_set[2] = 1'b1;
    if (s == REF_SLOT + XIN_AT + XIN_WIDTH)   e.pin_clr[2] = 1'b1;
    if (s == REF_SLOT + XOUT_AT)              e.pin_set[3] = 1'b1;
    if (s == REF_SLOT + XOUT_AT + XOUT_WIDTH) e.pin_clr[3] = 1'b1;
    if (s == REF_SLOT + STR_ON)               e.pin_set[4] = 1'b1;
    if (s == REF_SLOT + STR_OFF)              e.pin_clr[4] = 1'b1;
    return e;
  endfunction

endpackage

// ===== rtl/bfcs_in_if.sv =====
// Input channel: one tick item with valid/ready handshake.
interface bfcs_in_if;
  import bfcs_pkg::*;
  logic     valid;
  logic     ready;
  in_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bfcs_out_if.sv =====
// Output channel: one result item with valid/ready handshake.
interface bfcs_out_if;
  import bfcs_pkg::*;
  logic      valid;
  logic      ready;
  out_item_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

// ===== rtl/bubble_field_cycle_sequencer.sv =====
// Bubble drive field cycle sequencer: one input item per 0.25 us tick, one result
// item per tick. Throughput is one item per clock while the output is not stalled;
// each result is held in an output register. The edge schedule of the next slot is
// prefetched from a synchronous schedule memory, addressed by the slot the next
// item will execute, so the slot logic never waits on the read. A start is taken
// only while idle; slots past the last scheduled edge read an empty entry.
module bubble_field_cycle_sequencer #(
  parameter int LOOP_LENGTH = 641
) (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         cfg_we,
  input  logic                         cfg_index,
  input  logic [bfcs_pkg::CFG_W-1:0]   cfg_data,
  bfcs_in_if.sink                      req,
  bfcs_out_if.source                   rsp
);
  import bfcs_pkg::*;

  logic [CFG_W-1:0]  long_cycle_slots;
  logic [CFG_W-1:0]  short_cycle_slots;
  logic [SLOT_W-1:0] slot_counter, slot_counter_next;
  logic              running, running_next;
  logic [4:0]        held_function, held_function_next;
  logic              held_long, held_long_next;
  logic [3:0]        bridge_levels, bridge_levels_next;
  logic [1:0]        enable_levels, enable_levels_next;
  logic [4:0]        pin_levels, pin_levels_next;
  logic              detector_latch, detector_latch_next;
  logic [LOOP_W-1:0] loop_counter, loop_counter_next;
  logic              out_valid;
  out_item_t         out_data, out_data_next;

  sched_t                sched;
  logic [SCHED_AW-1:0]   sched_addr;
  logic                  accept;
  logic                  start;
  logic                  active;
  logic [4:0]            mask;
  logic                  sel_long;
  logic [4:0]            pin_clr;
  logic [3:0]            bridge_new;
  logic [1:0]            enable_new;
  logic [4:0]            pin_new;
  logic                  latch_new;
  logic [CFG_W-1:0]      len;
  logic                  done;
  logic [LOOP_W:0]       loop_inc;
  logic [SLOT_W-1:0]     addr_slot;
  logic                  addr_run;

  assign req.ready = !out_valid || rsp.ready;
  assign accept    = req.valid && req.ready;
  assign rsp.valid = out_valid;
  assign rsp.data  = out_data;

  assign start    = !running && req.data.action;
  assign active   = running || start;
  assign mask     = running ? held_function : req.data.function_mask;
  assign sel_long = running ? held_long : req.data.detect_mode;

  always_comb begin
    pin_clr    = sched.pin_clr_all ? 5'h1F : (sched.pin_clr & mask);
    bridge_new = (bridge_levels & ~sched.bridge_clr) | sched.bridge_set;
    enable_new = (enable_levels & ~sched.en_clr) | sched.en_set;
    pin_new    = (pin_levels & ~pin_clr) | (sched.pin_set & mask);
    latch_new  = (running && detector_latch) || req.data.detector_level;
    len        = sel_long ? long_cycle_slots : short_cycle_slots;
    if (len == '0) begin
      len = CFG_W'(1);
    end
    done     = active && (({1'b0, slot_counter} + (SLOT_W+1)'(1)) >= {1'b0, len});
    loop_inc = {1'b0, loop_counter} + (LOOP_W+1)'(1);
    if (loop_inc >= (LOOP_W+1)'(LOOP_LENGTH)) begin
      loop_inc = loop_inc - (LOOP_W+1)'(LOOP_LENGTH);
    end
  end

  always_comb begin
    slot_counter_next   = slot_counter;
    running_next        = running;
    held_function_next  = held_function;
    held_long_next      = held_long;
    bridge_levels_next  = bridge_levels;
    enable_levels_next  = enable_levels;
    pin_levels_next     = pin_levels;
    detector_latch_next = detector_latch;
    loop_counter_next   = loop_counter;
    if (active) begin
      held_function_next = mask;
      held_long_next     = sel_long;
      bridge_levels_next = bridge_new;
      if (done) begin
        running_next        = 1'b0;
        slot_counter_next   = '0;
        enable_levels_next  = '0;
        pin_levels_next     = '0;
        detector_latch_next = 1'b0;
        loop_counter_next   = loop_inc[LOOP_W-1:0];
      end else begin
        running_next        = 1'b1;
        slot_counter_next   = slot_counter + SLOT_W'(1);
        enable_levels_next  = enable_new;
        pin_levels_next     = pin_new;
        detector_latch_next = latch_new;
      end
    end
  end

  always_comb begin
    out_data_next                = '0;
    out_data_next.bridge_inputs  = active ? bridge_new : bridge_levels;
    out_data_next.bridge_enables = active ? enable_new : enable_levels;
    out_data_next.function_pins  = active ? pin_new : pin_levels;
    out_data_next.drive_safety   = active;
    out_data_next.busy_res       = active;
    out_data_next.cycle_done     = done;
    out_data_next.detected_bit   = done && latch_new;
    out_data_next.loop_position  = done ? loop_inc[LOOP_W-1:0] : loop_counter;
  end

  // prefetch the entry for the slot the next item executes
  always_comb begin
    addr_run  = accept ? running_next : running;
    addr_slot = accept ? slot_counter_next : slot_counter;
    if (rst || !addr_run) begin
      sched_addr = '0;
    end else if (addr_slot >= SLOT_W'(SCHED_DEPTH - 1)) begin
      sched_addr = SCHED_AW'(SCHED_DEPTH - 1);
    end else begin
      sched_addr = addr_slot[SCHED_AW-1:0];
    end
  end

  bfcs_sched_rom u_sched (
    .clk     (clk),
    .addr    (sched_addr),
    .rd_data (sched)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      long_cycle_slots  <= LONG_RESET;
      short_cycle_slots <= SHORT_RESET;
    end else if (cfg_we) begin
      case (cfg_reg_t'(cfg_index))
        REG_LONG:  long_cycle_slots  <= cfg_data;
        REG_SHORT: short_cycle_slots <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      slot_counter   <= '0;
      running        <= 1'b0;
      held_function  <= '0;
      held_long      <= 1'b0;
      bridge_levels  <= '0;
      enable_levels  <= '0;
      pin_levels     <= '0;
      detector_latch <= 1'b0;
      loop_counter   <= '0;
      out_valid      <= 1'b0;
    end else begin
      if (accept) begin
        slot_counter   <= slot_counter_next;
        running        <= running_next;
        held_function  <= held_function_next;
        held_long      <= held_long_next;
        bridge_levels  <= bridge_levels_next;
        enable_levels  <= enable_levels_next;
        pin_levels     <= pin_levels_next;
        detector_latch <= detector_latch_next;
        loop_counter   <= loop_counter_next;
        out_valid      <= 1'b1;
      end else if (rsp.ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_data <= out_data_next;
    end
  end

  a_idle_quiet: assert property (@(posedge clk) disable iff (rst)
    !running |-> (enable_levels == '0 && pin_levels == '0 && slot_counter == '0))
    else $error("idle with drive levels or slot count set");

  a_done_ends: assert property (@(posedge clk) disable iff (rst)
    accept && done |=> !running && slot_counter == '0)
    else $error("cycle did not close after last slot");

  a_slot_step: assert property (@(posedge clk) disable iff (rst)
    accept && active && !done |=> running && slot_counter == $past(slot_counter) + SLOT_W'(1))
    else $error("slot counter did not advance");

  a_loop_range: assert property (@(posedge clk) disable iff (rst)
    {1'b0, loop_counter} < (LOOP_W+1)'(LOOP_LENGTH))
    else $error("loop position out of range");

  a_busy_result: assert property (@(posedge clk) disable iff (rst)
    rsp.valid && rsp.data.cycle_done |-> rsp.data.busy_res && rsp.data.drive_safety)
    else $error("cycle end reported outside a cycle");

endmodule

// ===== rtl/bfcs_sched_rom.sv =====
// Slot schedule memory with a synchronous (registered) read.
module bfcs_sched_rom (
  input  logic                             clk,
  input  logic [bfcs_pkg::SCHED_AW-1:0]    addr,
  output bfcs_pkg::sched_t                 rd_data
);
  import bfcs_pkg::*;

  sched_t mem [SCHED_DEPTH];

  always_comb begin
    for (int i = 0; i < SCHED_DEPTH; i++) begin
      mem[i] = sched_entry(SCHED_AW'(i));
    end
  end

  always_ff @(posedge clk) begin
    rd_data <= mem[addr];
  end

endmodule
